// File: rtl/core/mpd_pkg.sv
// Shared types and constants for the multichannel presence debouncer.
// No dependencies; imported by every module of the block.
`default_nettype none
package mpd_pkg;

  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 32;

  // Fixed field widths
  localparam int NOW_W    = 32;
  localparam int STABLE_W = 16;
  localparam int CODES_W  = 2 * CHANNELS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [STABLE_W-1:0] STABLE_RESET = 16'd500;

  // Stream packing: first field in the lowest bits, padded to whole bytes
  localparam int IN_BITS  = NOW_W + 2 * CHANNELS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = CODES_W + 4;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_ASSIGN = 2'd1,
    REG_STABLE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CODE_ABSENT     = 2'd0,
    CODE_PRESENT    = 2'd1,
    CODE_UNASSIGNED = 2'd2,
    CODE_ERROR      = 2'd3
  } code_e;

  typedef enum logic [1:0] {
    ST_DISABLED = 2'd0,
    ST_READY    = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  typedef struct packed {
    code_e code;    // code reported after this request
    logic  fault;   // assigned and sensor fault
    logic  ok;      // assigned and fault free
    logic  primed;  // lane has taken its first level
  } lane_res_t;

  // Last member sits in the lowest bits, so codes come out at bit 0
  typedef struct packed {
    logic               valid_data;
    logic               error_code;
    status_e            status;
    logic [CODES_W-1:0] codes;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/mpd_lane.sv
// One debounce lane: level, change timestamp, reported code and prime flag.
// Depends on mpd_pkg.
`default_nettype none
module mpd_lane (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     step_i,
  input  logic                                     assigned_i,
  input  logic                                     level_i,
  input  logic                                     fault_i,
  input  logic [mpd_pkg::TIME_BITS-1:0]            now_i,
  input  logic [mpd_pkg::STABLE_W-1:0]             stable_i,
  output mpd_pkg::lane_res_t                       res_o
);
  import mpd_pkg::*;

  logic                 last_q, last_d;
  logic [TIME_BITS-1:0] ct_q, ct_d;
  code_e                code_q, code_d;
  logic                 primed_q, primed_d;

  logic                 lvl_eff;
  logic [TIME_BITS-1:0] ct_eff;
  code_e                code_eff;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    // unprimed lane takes the raw level at once
    lvl_eff  = primed_q ? last_q : level_i;
    ct_eff   = primed_q ? ct_q : now_i;
    code_eff = primed_q ? code_q : code_e'({1'b0, level_i});
    elapsed  = now_i - ct_eff;

    last_d   = last_q;
    ct_d     = ct_q;
    code_d   = code_q;
    primed_d = primed_q;
    if (step_i) begin
      if (!assigned_i) begin
        code_d = CODE_UNASSIGNED;
      end else begin
        primed_d = 1'b1;
        last_d   = lvl_eff;
        ct_d     = ct_eff;
        code_d   = code_eff;
        if (level_i != lvl_eff) begin
          last_d = level_i;
          ct_d   = now_i;
        end else if (elapsed >= TIME_BITS'(stable_i)) begin
          code_d = code_e'({1'b0, lvl_eff});
        end
        if (fault_i) code_d = CODE_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b0;
      ct_q     <= '0;
      code_q   <= CODE_UNASSIGNED;
      primed_q <= 1'b0;
    end else begin
      last_q   <= last_d;
      ct_q     <= ct_d;
      code_q   <= code_d;
      primed_q <= primed_d;
    end
  end

  assign res_o.code   = code_d;
  assign res_o.fault  = assigned_i & fault_i;
  assign res_o.ok     = assigned_i & ~fault_i;
  assign res_o.primed = primed_q;

endmodule
`default_nettype wire

// File: rtl/core/mpd_merge.sv
// Merge stage: packs lane codes, derives status, sticky error code, valid flag.
// Depends on mpd_pkg.
`default_nettype none
module mpd_merge (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     accept_i,
  input  logic                                     enabled_i,
  input  mpd_pkg::lane_res_t [mpd_pkg::CHANNELS-1:0] lanes_i,
  output mpd_pkg::result_t                         result_o
);
  import mpd_pkg::*;

  logic held_err_q, held_err_d;
  logic any_err, any_ok;

  always_comb begin
    any_err = 1'b0;
    any_ok  = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      any_err = any_err | lanes_i[i].fault;
      any_ok  = any_ok | lanes_i[i].ok;
      result_o.codes[2*i +: 2] = lanes_i[i].code;
    end
    held_err_d = held_err_q;
    if (accept_i && enabled_i) held_err_d = any_err;

    if (!enabled_i) begin
      result_o.status     = ST_DISABLED;
      result_o.error_code = held_err_q;
      result_o.valid_data = 1'b0;
    end else begin
      result_o.status     = any_err ? ST_ERROR : ST_READY;
      result_o.error_code = any_err;
      result_o.valid_data = any_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) held_err_q <= 1'b0;
    else         held_err_q <= held_err_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/multichannel_presence_debouncer.sv
// Top level of the multichannel presence debouncer: config registers, lanes,
// merge stage and result register. Depends on mpd_pkg, mpd_lane, mpd_merge.
`default_nettype none
// Debounces CHANNELS presence inputs by millisecond timestamp. Each input
// request carries the current time, the raw levels and the sensor fault flags;
// each produces exactly one result with two-bit codes per channel (0 absent,
// 1 present, 2 unassigned, 3 error), a module status, a sticky error code and
// a valid flag. Throughput is one request per clock while results drain; each
// channel has its own lane (one 32-bit subtract and compare), and the merged
// result lands in an output register in the cycle after the request is taken.
// The input is ready whenever that register is empty or being drained this
// cycle, so a stalled consumer stalls the input only while a result is pending.
// Configuration is written through a plain write port, by the user only while
// no request is in flight (unenforced); unknown register indexes are ignored.
module multichannel_presence_debouncer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mpd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: now_time_ms, raw_levels, sensor_faults
  input  logic [mpd_pkg::IN_W-1:0]           s_axis_tdata,
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: presence_codes, module_status, error_code, valid_data,
  // zero padding
  output logic [mpd_pkg::OUT_W-1:0]          m_axis_tdata
);
  import mpd_pkg::*;

  // Configuration registers
  logic                enable_q;
  logic [CHANNELS-1:0] assign_q;
  logic [STABLE_W-1:0] stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      assign_q <= '0;
      stable_q <= STABLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: enable_q <= cfg_wdata_i[0];
        REG_ASSIGN: assign_q <= cfg_wdata_i[CHANNELS-1:0];
        REG_STABLE: stable_q <= cfg_wdata_i[STABLE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Unpack the request
  logic [TIME_BITS-1:0] now;
  logic [CHANNELS-1:0]  raw;
  logic [CHANNELS-1:0]  faults;

  assign now    = s_axis_tdata[TIME_BITS-1:0];
  assign raw    = s_axis_tdata[NOW_W +: CHANNELS];
  assign faults = s_axis_tdata[NOW_W + CHANNELS +: CHANNELS];

  logic s_accept;
  logic out_valid_q;
  result_t out_q;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  // Lanes: state moves only on an accepted request while enabled
  lane_res_t [CHANNELS-1:0] lane_res;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mpd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (s_accept & enable_q),
      .assigned_i (assign_q[g]),
      .level_i    (raw[g]),
      .fault_i    (faults[g]),
      .now_i      (now),
      .stable_i   (stable_q),
      .res_o      (lane_res[g])
    );
  end

  result_t merged;

  mpd_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (s_accept),
    .enabled_i (enable_q),
    .lanes_i   (lane_res),
    .result_o  (merged)
  );

  // Result register decouples the two sides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) out_q <= merged;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  // Primed flags of all lanes, for checking
  logic [CHANNELS-1:0] primed_all;
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) primed_all[i] = lane_res[i].primed;
  end

  // Every accepted request shows a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // Input stalls only behind a pending result
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q)
    else $error("input stalled with empty result register");

  // Error status implies that the error code is set
  a_status_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status == ST_ERROR) |-> out_q.error_code)
    else $error("error status without error code");

  // Once primed, a lane stays primed
  a_primed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(primed_all) & ~primed_all) == '0))
    else $error("lane lost its primed flag");

endmodule
`default_nettype wire
